### rtl/rhs_pkg.sv
// shared types and constants for the two-key record heapsort
`default_nettype none

package rhs_pkg;

   localparam int MAX_RECORDS_DEFAULT = 64;
   localparam int GROUP_KEY_W = 16;
   localparam int ITEM_KEY_W  = 32;
   localparam int TAG_W       = 16;
   localparam int KEY_W       = GROUP_KEY_W + ITEM_KEY_W;
   localparam int REC_W       = KEY_W + TAG_W;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SETUP,
      OP_DEC_K,
      OP_RD_TAIL,
      OP_HELD_K,
      OP_HELD_M,
      OP_MOVE_ROOT,
      OP_FINAL_ROOT,
      OP_RD_CHILD_A,
      OP_CHILD_A,
      OP_CHILD_B,
      OP_SINK,
      OP_PLACE,
      OP_EMIT_RD,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic n_ge2;
      logic k_gt1;
      logic m_eq2;
      logic j_le_m;
      logic j_lt_m;
      logic held_lt_a;
      logic emit_last;
   } status_type;

endpackage

`default_nettype wire

### rtl/rhs_ctrl.sv
// sequencer for load, heap build, extraction and emit
`default_nettype none

module rhs_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  wire               req_last_in,
   input  rhs_pkg::status_type st,
   output rhs_pkg::op_type   op,
   output logic              busy,
   output logic              rsp_strobe
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_OUTER,
      S_HELD_K,
      S_HELD_M,
      S_MOVE_ROOT,
      S_FINAL_ROOT,
      S_SIFT,
      S_CHILD_A,
      S_CHILD_B,
      S_CMP,
      S_EMIT_RD,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      strobe_ff;

   always_comb begin
      state_in = state_ff;
      op       = rhs_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy_ff) begin
               op = rhs_pkg::OP_LOAD;
               if (req_last_in) begin
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            op       = rhs_pkg::OP_SETUP;
            state_in = st.n_ge2 ? S_OUTER : S_EMIT_RD;
         end
         S_OUTER: begin
            if (st.k_gt1) begin
               op       = rhs_pkg::OP_DEC_K;
               state_in = S_HELD_K;
            end else begin
               op       = rhs_pkg::OP_RD_TAIL;
               state_in = S_HELD_M;
            end
         end
         S_HELD_K: begin
            op       = rhs_pkg::OP_HELD_K;
            state_in = S_SIFT;
         end
         S_HELD_M: begin
            op       = rhs_pkg::OP_HELD_M;
            state_in = S_MOVE_ROOT;
         end
         S_MOVE_ROOT: begin
            op       = rhs_pkg::OP_MOVE_ROOT;
            state_in = st.m_eq2 ? S_FINAL_ROOT : S_SIFT;
         end
         S_FINAL_ROOT: begin
            op       = rhs_pkg::OP_FINAL_ROOT;
            state_in = S_EMIT_RD;
         end
         S_SIFT: begin
            if (st.j_le_m) begin
               op       = rhs_pkg::OP_RD_CHILD_A;
               state_in = S_CHILD_A;
            end else begin
               op       = rhs_pkg::OP_PLACE;
               state_in = S_OUTER;
            end
         end
         S_CHILD_A: begin
            op       = rhs_pkg::OP_CHILD_A;
            state_in = st.j_lt_m ? S_CHILD_B : S_CMP;
         end
         S_CHILD_B: begin
            op       = rhs_pkg::OP_CHILD_B;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (st.held_lt_a) begin
               op       = rhs_pkg::OP_SINK;
               state_in = S_SIFT;
            end else begin
               op       = rhs_pkg::OP_PLACE;
               state_in = S_OUTER;
            end
         end
         S_EMIT_RD: begin
            op       = rhs_pkg::OP_EMIT_RD;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            op = rhs_pkg::OP_EMIT;
            if (st.emit_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in != S_IDLE);
         strobe_ff <= (state_ff == S_EMIT);
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

### rtl/rhs_dp.sv
// record store, heap index registers, key compares and result registers
`default_nettype none

module rhs_dp #(
   parameter int MAX_RECORDS = rhs_pkg::MAX_RECORDS_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  rhs_pkg::op_type                  op,
   input  wire [rhs_pkg::GROUP_KEY_W-1:0]   req_group_key,
   input  wire [rhs_pkg::ITEM_KEY_W-1:0]    req_item_key,
   input  wire [rhs_pkg::TAG_W-1:0]         req_tag,
   output rhs_pkg::status_type              st,
   output logic [rhs_pkg::GROUP_KEY_W-1:0]  rsp_out_group_key,
   output logic [rhs_pkg::ITEM_KEY_W-1:0]   rsp_out_item_key,
   output logic [rhs_pkg::TAG_W-1:0]        rsp_out_tag,
   output logic                             rsp_last_out,
   output logic                             rsp_overflow
);

   localparam int AddrW = $clog2(MAX_RECORDS);
   localparam int CntW  = $clog2(MAX_RECORDS + 1);
   localparam int IdxW  = $clog2(MAX_RECORDS) + 2;
   localparam int RecW  = rhs_pkg::REC_W;
   localparam int KeyW  = rhs_pkg::KEY_W;
   localparam int TagW  = rhs_pkg::TAG_W;

   logic [RecW-1:0]  store_ff [MAX_RECORDS];
   logic [RecW-1:0]  rdata_ff;
   logic [RecW-1:0]  held_ff;
   logic [RecW-1:0]  a_ff;
   logic [CntW-1:0]  count_ff;
   logic             ovf_ff;
   logic [IdxW-1:0]  k_ff, m_ff, i_ff, j_ff, e_ff, cnt_idx;
   logic [RecW-1:0]  out_rec_ff;
   logic             out_last_ff;
   logic             out_ovf_ff;

   logic             rd_en;
   logic [AddrW-1:0] rd_addr;
   logic             wr_en;
   logic [AddrW-1:0] wr_addr;
   logic [RecW-1:0]  wr_data;
   logic             room;

   assign cnt_idx = IdxW'(count_ff);
   assign room    = (count_ff < CntW'(MAX_RECORDS));

   assign st.n_ge2     = (count_ff >= CntW'(2));
   assign st.k_gt1     = (k_ff > IdxW'(1));
   assign st.m_eq2     = (m_ff == IdxW'(2));
   assign st.j_le_m    = (j_ff <= m_ff);
   assign st.j_lt_m    = (j_ff < m_ff);
   assign st.held_lt_a = (held_ff[RecW-1:TagW] < a_ff[RecW-1:TagW]);
   assign st.emit_last = (e_ff == cnt_idx);

   // memory port selection
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = held_ff;
      unique case (op)
         rhs_pkg::OP_LOAD: begin
            wr_en   = room;
            wr_addr = AddrW'(count_ff);
            wr_data = {req_group_key, req_item_key, req_tag};
         end
         rhs_pkg::OP_DEC_K: begin
            rd_en   = 1'b1;
            rd_addr = AddrW'(k_ff - IdxW'(2));
         end
         rhs_pkg::OP_RD_TAIL: begin
            rd_en   = 1'b1;
            rd_addr = AddrW'(m_ff - IdxW'(1));
         end
         rhs_pkg::OP_HELD_M: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         rhs_pkg::OP_MOVE_ROOT: begin
            wr_en   = 1'b1;
            wr_addr = AddrW'(m_ff - IdxW'(1));
            wr_data = rdata_ff;
         end
         rhs_pkg::OP_FINAL_ROOT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
         end
         rhs_pkg::OP_RD_CHILD_A: begin
            rd_en   = 1'b1;
            rd_addr = AddrW'(j_ff - IdxW'(1));
         end
         rhs_pkg::OP_CHILD_A: begin
            rd_en   = 1'b1;
            rd_addr = AddrW'(j_ff);
         end
         rhs_pkg::OP_SINK: begin
            wr_en   = 1'b1;
            wr_addr = AddrW'(i_ff - IdxW'(1));
            wr_data = a_ff;
         end
         rhs_pkg::OP_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = AddrW'(i_ff - IdxW'(1));
         end
         rhs_pkg::OP_EMIT_RD, rhs_pkg::OP_EMIT: begin
            rd_en   = 1'b1;
            rd_addr = AddrW'(e_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= store_ff[rd_addr];
      end
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (op == rhs_pkg::OP_LOAD) begin
         if (room) begin
            count_ff <= count_ff + CntW'(1);
         end else begin
            ovf_ff <= 1'b1;
         end
      end else if (op == rhs_pkg::OP_EMIT && st.emit_last) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end
   end

   // heap indexes, held record, child record and result registers
   always_ff @(posedge clock) begin
      unique case (op)
         rhs_pkg::OP_SETUP: begin
            k_ff <= (cnt_idx >> 1) + IdxW'(1);
            m_ff <= cnt_idx;
            e_ff <= '0;
         end
         rhs_pkg::OP_DEC_K: begin
            k_ff <= k_ff - IdxW'(1);
         end
         rhs_pkg::OP_HELD_K: begin
            held_ff <= rdata_ff;
            i_ff    <= k_ff;
            j_ff    <= k_ff << 1;
         end
         rhs_pkg::OP_HELD_M: begin
            held_ff <= rdata_ff;
         end
         rhs_pkg::OP_MOVE_ROOT: begin
            m_ff <= m_ff - IdxW'(1);
            i_ff <= k_ff;
            j_ff <= k_ff << 1;
         end
         rhs_pkg::OP_FINAL_ROOT: begin
            e_ff <= '0;
         end
         rhs_pkg::OP_CHILD_A: begin
            a_ff <= rdata_ff;
         end
         rhs_pkg::OP_CHILD_B: begin
            if (a_ff[RecW-1:TagW] < rdata_ff[RecW-1:TagW]) begin
               a_ff <= rdata_ff;
               j_ff <= j_ff + IdxW'(1);
            end
         end
         rhs_pkg::OP_SINK: begin
            i_ff <= j_ff;
            j_ff <= j_ff << 1;
         end
         rhs_pkg::OP_EMIT_RD: begin
            e_ff <= e_ff + IdxW'(1);
         end
         rhs_pkg::OP_EMIT: begin
            e_ff        <= e_ff + IdxW'(1);
            out_rec_ff  <= rdata_ff;
            out_last_ff <= st.emit_last;
            out_ovf_ff  <= ovf_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_out_group_key = out_rec_ff[RecW-1:KeyW-rhs_pkg::GROUP_KEY_W+TagW];
   assign rsp_out_item_key  = out_rec_ff[KeyW-rhs_pkg::GROUP_KEY_W+TagW-1:TagW];
   assign rsp_out_tag       = out_rec_ff[TagW-1:0];
   assign rsp_last_out      = out_last_ff;
   assign rsp_overflow      = out_ovf_ff;

endmodule

`default_nettype wire

### rtl/record_heapsort_two_key_top.sv
// top level of the two-key record heapsort
// load: one record per cycle while busy is low; a record with last_in starts the sort
// sort: in-place heapsort on a single-port record memory with registered read, taking
//   about N log2 N sift levels for N records
// emit: sorted records one per cycle after the emit read state, strobe high one cycle each
// synchronous active-high reset clears the sequencer, record count and overflow flag
`default_nettype none

module record_heapsort_two_key_top #(
   parameter int MAX_RECORDS = rhs_pkg::MAX_RECORDS_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire [rhs_pkg::GROUP_KEY_W-1:0]   req_group_key,
   input  wire [rhs_pkg::ITEM_KEY_W-1:0]    req_item_key,
   input  wire [rhs_pkg::TAG_W-1:0]         req_tag,
   input  wire                              req_last_in,
   output logic                             rsp_strobe,
   output logic [rhs_pkg::GROUP_KEY_W-1:0]  rsp_out_group_key,
   output logic [rhs_pkg::ITEM_KEY_W-1:0]   rsp_out_item_key,
   output logic [rhs_pkg::TAG_W-1:0]        rsp_out_tag,
   output logic                             rsp_last_out,
   output logic                             rsp_overflow
);

   rhs_pkg::op_type     op;
   rhs_pkg::status_type st;

   rhs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_last_in (req_last_in),
      .st          (st),
      .op          (op),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe)
   );

   rhs_dp #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .req_group_key     (req_group_key),
      .req_item_key      (req_item_key),
      .req_tag           (req_tag),
      .st                (st),
      .rsp_out_group_key (rsp_out_group_key),
      .rsp_out_item_key  (rsp_out_item_key),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_last_out      (rsp_last_out),
      .rsp_overflow      (rsp_overflow)
   );

endmodule

`default_nettype wire

### bench/record_heapsort_two_key_top_test.sv
`timescale 1ns / 100ps
// testbench for the two-key record heapsort: record sets checked against a heapsort predictor
module record_heapsort_two_key_top_test;

   localparam int DEPTH       = rhs_pkg::MAX_RECORDS_DEFAULT;
   localparam int GroupW      = rhs_pkg::GROUP_KEY_W;
   localparam int ItemW       = rhs_pkg::ITEM_KEY_W;
   localparam int TagW        = rhs_pkg::TAG_W;
   localparam int KeyW        = rhs_pkg::KEY_W;
   localparam int STALL_LIMIT = 40000;
   localparam int ITEM_TARGET = 430;

   typedef struct packed {
      logic [GroupW-1:0] group_key;
      logic [ItemW-1:0]  item_key;
      logic [TagW-1:0]   tag;
   } record_type;

   typedef struct {
      record_type rec;
      logic       last_out;
      logic       overflow;
   } sorted_out_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [GroupW-1:0] req_group_key;
   logic [ItemW-1:0]  req_item_key;
   logic [TagW-1:0]   req_tag;
   logic              req_last_in;
   logic              rsp_strobe;
   logic [GroupW-1:0] rsp_out_group_key;
   logic [ItemW-1:0]  rsp_out_item_key;
   logic [TagW-1:0]   rsp_out_tag;
   logic              rsp_last_out;
   logic              rsp_overflow;

   record_type     held_records [DEPTH];
   int unsigned    held_count;
   logic           drop_seen;
   sorted_out_type sorted_due [$];

   bit idle_on;
   int error_count;
   int records_sent;
   int records_dropped;
   int sets_done;
   int sets_overflowed;
   int results_checked;
   int stall_cycles;

   record_heapsort_two_key_top #(
      .MAX_RECORDS(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_group_key(req_group_key),
      .req_item_key(req_item_key),
      .req_tag(req_tag),
      .req_last_in(req_last_in),
      .rsp_strobe(rsp_strobe),
      .rsp_out_group_key(rsp_out_group_key),
      .rsp_out_item_key(rsp_out_item_key),
      .rsp_out_tag(rsp_out_tag),
      .rsp_last_out(rsp_last_out),
      .rsp_overflow(rsp_overflow)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic logic [KeyW-1:0] order_key(record_type r);
      return {r.group_key, r.item_key};
   endfunction

   task automatic heapsort_held(int unsigned n);
      int unsigned k;
      int unsigned m;
      int unsigned i;
      int unsigned j;
      record_type  held;
      bit          done;
      k    = (n >> 1) + 1;
      m    = n;
      done = 1'b0;
      while (!done) begin
         if (k > 1) begin
            k--;
            held = held_records[k-1];
         end else begin
            held = held_records[m-1];
            held_records[m-1] = held_records[0];
            m--;
            if (m == 1) begin
               held_records[0] = held;
               done = 1'b1;
            end
         end
         if (!done) begin
            i = k;
            j = k << 1;
            while (j <= m) begin
               if (j < m && order_key(held_records[j-1]) < order_key(held_records[j]))
                  j++;
               if (order_key(held) < order_key(held_records[j-1])) begin
                  held_records[i-1] = held_records[j-1];
                  i = j;
                  j = j + j;
               end else begin
                  j = m + 1;
               end
            end
            held_records[i-1] = held;
         end
      end
   endtask

   // predictor: store the record, sort and queue the set when it ends
   task automatic absorb_record(record_type r, logic last);
      sorted_out_type due;
      if (held_count < DEPTH) begin
         held_records[held_count] = r;
         held_count++;
      end else begin
         drop_seen = 1'b1;
         records_dropped++;
      end
      if (last) begin
         if (held_count >= 2)
            heapsort_held(held_count);
         for (int a = 0; a < held_count; a++) begin
            due.rec      = held_records[a];
            due.last_out = (a + 1 == held_count);
            due.overflow = drop_seen;
            sorted_due.push_back(due);
         end
         sets_done++;
         if (drop_seen)
            sets_overflowed++;
         held_count = 0;
         drop_seen  = 1'b0;
      end
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
   endtask

   // one input transfer; start stays high so the next record can follow at once
   task automatic send_record(record_type r, logic last);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 2) == 0)
         gap = $urandom_range(1, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_group_key <= r.group_key;
      req_item_key  <= r.item_key;
      req_tag       <= r.tag;
      req_last_in   <= last;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      records_sent++;
      absorb_record(r, last);
   endtask

   function automatic record_type random_record(int spread);
      record_type r;
      r.tag = TagW'($urandom);
      case (spread)
         0: begin
            r.group_key = GroupW'($urandom_range(0, 3));
            r.item_key  = ItemW'($urandom_range(0, 3));
         end
         1: begin
            r.group_key = GroupW'($urandom);
            r.item_key  = ItemW'($urandom);
         end
         2: begin
            r.group_key = ~GroupW'($urandom_range(0, 2));
            r.item_key  = ~ItemW'($urandom_range(0, 2));
         end
         default: begin
            r.group_key = GroupW'($urandom_range(0, 2));
            r.item_key  = ItemW'($urandom);
         end
      endcase
      return r;
   endfunction

   task automatic send_set(int n, int spread);
      for (int idx = 0; idx < n; idx++)
         send_record(random_record(spread), idx == n - 1);
   endtask

   task automatic close_phase();
      start <= 1'b0;
      @(posedge clock);
      while (sorted_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_single_records();
      send_record('{16'h0000, 32'h0000_0000, 16'h0000}, 1'b1);
      send_record('{16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1);
      close_phase();
   endtask

   task automatic test_extremes_and_ties();
      send_record('{16'hFFFF, 32'hFFFF_FFFF, 16'h0001}, 1'b0);
      send_record('{16'h0000, 32'h0000_0000, 16'hFFFF}, 1'b0);
      send_record('{16'h0000, 32'hFFFF_FFFF, 16'h0002}, 1'b0);
      send_record('{16'hFFFF, 32'h0000_0000, 16'h0003}, 1'b0);
      send_record('{16'h0005, 32'h0000_0007, 16'h000A}, 1'b0);
      send_record('{16'h0005, 32'h0000_0007, 16'h000B}, 1'b0);
      send_record('{16'h0005, 32'h0000_0007, 16'h000C}, 1'b0);
      send_record('{16'h0005, 32'h0000_0006, 16'h000D}, 1'b1);
      close_phase();
   endtask

   // group key descends while item key ascends
   task automatic test_group_before_item();
      record_type r;
      for (int idx = 0; idx < 10; idx++) begin
         r.group_key = GroupW'((9 - idx) / 2);
         r.item_key  = ItemW'(idx) << 28;
         r.tag       = TagW'(16'h0100 + idx);
         send_record(r, idx == 9);
      end
      close_phase();
   endtask

   // exactly full, then a dropped last record, then several drops before it
   task automatic test_full_store();
      idle_on = 1'b1;
      send_set(DEPTH, 1);
      close_phase();
      send_set(DEPTH + 1, 0);
      close_phase();
      send_set(DEPTH + 4, 3);
      close_phase();
   endtask

   task automatic test_random_sets();
      int n;
      while (records_sent < ITEM_TARGET - 45) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0)
            n = $urandom_range(20, DEPTH + 2);
         else
            n = $urandom_range(1, 10);
         send_set(n, $urandom_range(0, 3));
      end
      close_phase();
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      while (records_sent < ITEM_TARGET)
         send_set($urandom_range(1, 8), $urandom_range(0, 3));
      close_phase();
   endtask

   always @(posedge clock) begin : check_results
      sorted_out_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (rsp_strobe !== 1'b1) begin
            report_mismatch("strobe unknown", 64'(rsp_strobe), 64'd1);
         end else if (sorted_due.size() == 0) begin
            report_mismatch("result with nothing due", 64'(rsp_out_group_key), 64'd0);
         end else begin
            want = sorted_due.pop_front();
            results_checked++;
            if (rsp_out_group_key !== want.rec.group_key)
               report_mismatch("group key", 64'(rsp_out_group_key), 64'(want.rec.group_key));
            if (rsp_out_item_key !== want.rec.item_key)
               report_mismatch("item key", 64'(rsp_out_item_key), 64'(want.rec.item_key));
            if (rsp_out_tag !== want.rec.tag)
               report_mismatch("tag", 64'(rsp_out_tag), 64'(want.rec.tag));
            if (rsp_last_out !== want.last_out)
               report_mismatch("last flag", 64'(rsp_last_out), 64'(want.last_out));
            if (rsp_overflow !== want.overflow)
               report_mismatch("overflow flag", 64'(rsp_overflow), 64'(want.overflow));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles at %0t", stall_cycles, $time);
            $display("record_heapsort_two_key_top_test failed");
            $finish;
         end
      end
   end

   initial begin
      reset         <= 1'b1;
      start         <= 1'b0;
      req_group_key <= '0;
      req_item_key  <= '0;
      req_tag       <= '0;
      req_last_in   <= 1'b0;
      held_count      = 0;
      drop_seen       = 1'b0;
      idle_on         = 1'b1;
      error_count     = 0;
      records_sent    = 0;
      records_dropped = 0;
      sets_done       = 0;
      sets_overflowed = 0;
      results_checked = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_records();
      test_extremes_and_ties();
      test_group_before_item();
      test_full_store();
      test_random_sets();
      test_back_to_back();

      repeat (40) @(posedge clock);
      $display("sent %0d records in %0d sets, %0d sets with dropped records (%0d dropped)",
               records_sent, sets_done, sets_overflowed, records_dropped);
      $display("checked %0d sorted records, %0d mismatches", results_checked, error_count);
      if (error_count == 0 && sorted_due.size() == 0)
         $display("record_heapsort_two_key_top_test passed");
      else
         $display("record_heapsort_two_key_top_test failed");
      $finish;
   end

endmodule
